// ----- hdl/hvsr_pkg.sv -----
package hvsr_pkg;

    localparam int unsigned VOLTS_W    = 15;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned CURLIM_W   = 13;
    localparam int unsigned MEAS_W     = 17;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [VOLTS_W-1:0]  HARD_MAX_VOLTS    = VOLTS_W'(25000);
    localparam logic [CURLIM_W-1:0] HARD_MAX_CURRENT  = CURLIM_W'(75 * 100);
    localparam logic [STEP_W-1:0]   DEFAULT_STEP      = STEP_W'(10);
    localparam logic [TICKS_W-1:0]  DEFAULT_MIN_TICKS = TICKS_W'(100);
    localparam logic [TICKS_W-1:0]  TICKS_MAX         = '1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_DEMAND  = 2'd1,
        OP_MEASURE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAMP_UP_STEP   = 3'd0,
        REG_RAMP_DOWN_STEP = 3'd1,
        REG_VOLTAGE_LIMIT  = 3'd2,
        REG_CURRENT_LIMIT  = 3'd3,
        REG_MIN_STEP_TICKS = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        op_t                 op;
        logic [VOLTS_W-1:0]  demand_volts;
        logic [MEAS_W-1:0]   measured_current;
    } in_t;

    typedef struct packed {
        logic [VOLTS_W-1:0]  command_volts;
        logic                command_issued;
        logic                ramping_up;
        logic                ramping_down;
        logic                voltage_limited;
        logic                current_limited;
    } out_t;

endpackage

// ----- hdl/hv_setpoint_ramp_generator.sv -----
// High-voltage setpoint ramp generator. Every input word (tick, demand write or current
// measurement) yields exactly one result word. A word is captured into an input register,
// processed by one pass of add/compare/clamp logic against the ramp state, and the result
// lands in an output register. One word is taken every cycle while the output side keeps
// stall low. The input register holds its word while the output register is stalled.
// Configuration writes take effect at the next clock edge and should be made while no
// word is in flight.
module hv_setpoint_ramp_generator
    import hvsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [STEP_W-1:0]   up_step_reg;
    logic [STEP_W-1:0]   down_step_reg;
    logic [VOLTS_W-1:0]  volt_limit_reg;
    logic [CURLIM_W-1:0] cur_limit_reg;
    logic [TICKS_W-1:0]  min_ticks_reg;

    // ramp state
    logic [VOLTS_W-1:0]  actual_reg,  actual_next;
    logic [VOLTS_W-1:0]  target_reg,  target_next;
    logic                pending_reg, pending_next;
    logic                up_reg,      up_next;
    logic                down_reg,    down_next;
    logic [TICKS_W-1:0]  elapsed_reg, elapsed_next;
    logic                clamp_reg,   clamp_next;
    logic                trip_reg,    trip_next;
    logic                issued;

    // pipeline
    in_t                 in_reg;
    logic                in_valid_reg;
    out_t                out_reg, out_next;
    logic                out_valid_reg;
    logic                out_load;
    logic                advance;

    logic [VOLTS_W-1:0]  sat_volts;
    logic [CURLIM_W-1:0] sat_current;
    logic [VOLTS_W-1:0]  sat_demand;
    logic [TICKS_W-1:0]  elapsed_inc;
    logic [VOLTS_W:0]    up_sum;
    logic [VOLTS_W:0]    down_floor;

    assign out_load  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_load;
    assign in_stall  = in_valid_reg && !out_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sat_volts   = (cfg_data[VOLTS_W-1:0] > HARD_MAX_VOLTS)
                         ? HARD_MAX_VOLTS : cfg_data[VOLTS_W-1:0];
    assign sat_current = (cfg_data[CURLIM_W-1:0] > HARD_MAX_CURRENT)
                         ? HARD_MAX_CURRENT : cfg_data[CURLIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_step_reg    <= DEFAULT_STEP;
            down_step_reg  <= DEFAULT_STEP;
            volt_limit_reg <= HARD_MAX_VOLTS;
            cur_limit_reg  <= HARD_MAX_CURRENT;
            min_ticks_reg  <= DEFAULT_MIN_TICKS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RAMP_UP_STEP:   up_step_reg    <= cfg_data;
                REG_RAMP_DOWN_STEP: down_step_reg  <= cfg_data;
                REG_VOLTAGE_LIMIT:  volt_limit_reg <= sat_volts;
                REG_CURRENT_LIMIT:  cur_limit_reg  <= sat_current;
                REG_MIN_STEP_TICKS: min_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sat_demand  = (in_reg.demand_volts > HARD_MAX_VOLTS)
                         ? HARD_MAX_VOLTS : in_reg.demand_volts;
    assign elapsed_inc = (elapsed_reg != TICKS_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign up_sum      = {1'b0, actual_reg} + {1'b0, up_step_reg[VOLTS_W-1:0]};
    assign down_floor  = {1'b0, target_reg} + {1'b0, down_step_reg[VOLTS_W-1:0]};

    always_comb
    begin
        actual_next  = actual_reg;
        target_next  = target_reg;
        pending_next = pending_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        elapsed_next = elapsed_reg;
        clamp_next   = clamp_reg;
        trip_next    = trip_reg;
        issued       = 1'b0;

        case (in_reg.op)
            OP_DEMAND:
            begin
                target_next  = sat_demand;
                pending_next = 1'b1;
            end
            OP_MEASURE:
            begin
                trip_next = (in_reg.measured_current >= {{(MEAS_W-CURLIM_W){1'b0}},
                                                         cur_limit_reg});
            end
            OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (!trip_reg)
                begin
                    if (pending_reg)
                    begin
                        // restarting the interval rules out a step on this tick
                        if (target_reg > actual_reg && up_step_reg != '0)
                        begin
                            up_next      = 1'b1;
                            down_next    = 1'b0;
                            pending_next = 1'b0;
                        end
                        if (target_reg < actual_reg && down_step_reg != '0)
                        begin
                            up_next      = 1'b0;
                            down_next    = 1'b1;
                            pending_next = 1'b0;
                        end
                        elapsed_next = '0;
                    end
                    else if (up_reg && elapsed_inc > min_ticks_reg)
                    begin
                        // a step of 2^15 or more always reaches the target
                        if (up_step_reg[STEP_W-1:VOLTS_W] != '0
                            || up_sum >= {1'b0, target_reg})
                        begin
                            actual_next = target_reg;
                            up_next     = 1'b0;
                        end
                        else
                        begin
                            actual_next = up_sum[VOLTS_W-1:0];
                        end
                        issued       = 1'b1;
                        elapsed_next = '0;
                    end
                    else if (down_reg && elapsed_inc > min_ticks_reg)
                    begin
                        if (down_step_reg[STEP_W-1] || {1'b0, actual_reg} <= down_floor)
                        begin
                            actual_next = target_reg;
                            down_next   = 1'b0;
                        end
                        else
                        begin
                            actual_next = actual_reg - down_step_reg[VOLTS_W-1:0];
                        end
                        issued       = 1'b1;
                        elapsed_next = '0;
                    end
                end
            end
            default: ;
        endcase

        if (issued)
        begin
            clamp_next = (actual_next > volt_limit_reg);
        end

        out_next.command_volts   = (actual_next > volt_limit_reg) ? volt_limit_reg : actual_next;
        out_next.command_issued  = issued;
        out_next.ramping_up      = up_next;
        out_next.ramping_down    = down_next;
        out_next.voltage_limited = clamp_next;
        out_next.current_limited = trip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            actual_reg    <= '0;
            target_reg    <= '0;
            pending_reg   <= 1'b0;
            up_reg        <= 1'b0;
            down_reg      <= 1'b0;
            elapsed_reg   <= '0;
            clamp_reg     <= 1'b0;
            trip_reg      <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                actual_reg  <= actual_next;
                target_reg  <= target_next;
                pending_reg <= pending_next;
                up_reg      <= up_next;
                down_reg    <= down_next;
                elapsed_reg <= elapsed_next;
                clamp_reg   <= clamp_next;
                trip_reg    <= trip_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hdl/hvsr_checker.sv -----
module hvsr_checker
    import hvsr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.ramping_up && out_data.ramping_down))
        else $error("ramp active in both directions");

    a_volts_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.command_volts <= HARD_MAX_VOLTS)
        else $error("command above hard voltage maximum");

    // the ramp is frozen while tripped, so no setting may go out
    a_no_issue_tripped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.command_issued |-> !out_data.current_limited)
        else $error("command issued while current limited");

endmodule

bind hv_setpoint_ramp_generator hvsr_checker u_hvsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
